FILE: rtl/fcsr_pkg.sv
// Package for the framed CRC-16 status receiver.
// Holds the shared types, codes, register indexes and the CRC and command lookup functions.
// Has no dependencies of its own.
package fcsr_pkg;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_HEADER       = 3'd0;
    localparam logic [2:0] REG_END          = 3'd1;
    localparam logic [2:0] REG_REPORT_ALL   = 3'd2;
    localparam logic [2:0] REG_READ_ID      = 3'd3;
    localparam logic [2:0] REG_SET_ID_OK    = 3'd4;
    localparam logic [2:0] REG_READ_LEVEL   = 3'd5;
    localparam logic [2:0] REG_READ_CURRENT = 3'd6;
    localparam logic [2:0] REG_READ_ERROR   = 3'd7;

    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [2:0] KIND_REPORT_ALL = 3'd0;
    localparam logic [2:0] KIND_READ_ID    = 3'd1;
    localparam logic [2:0] KIND_SET_ID_OK  = 3'd2;
    localparam logic [2:0] KIND_LEVEL      = 3'd3;
    localparam logic [2:0] KIND_CURRENT    = 3'd4;
    localparam logic [2:0] KIND_ERROR      = 3'd5;
    localparam logic [2:0] KIND_OTHER      = 3'd6;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [7:0]  MIN_LEN  = 8'd6;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FRAME,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0]      header;
        logic [7:0]      end_byte;
        logic [5:0][7:0] codes;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [63:0] id;
        logic [7:0]  level;
        logic [15:0] current;
        logic [7:0]  error;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [2:0] kind_of(input logic [7:0] cmd, input t_cfg cfg);
        logic [2:0] k;
        k = KIND_OTHER;
        for (int i = 5; i >= 0; i--) begin
            if (cfg.codes[i] == cmd) begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

endpackage

FILE: rtl/framed_crc16_status_receiver_top.sv
// Top level of the framed CRC-16 status receiver.
// Input beat register, frame parser, result register and configuration port.
// Depends on fcsr_pkg, fcsr_regs and fcsr_parser.
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: rx_byte; tlast: burst_last
// m_axis    out        m_axis_tvalid/tready       tdata: id, level, current, error
//                                                 tuser: frame_status, command_kind
// apb       in         psel/penable/pready        8 registers at byte address 4*i
//
// One byte is taken every cycle while the result register is not stalled; a byte is taken into
// the input register, then passes the combinational CRC and parse logic into the result register.
// Reset is synchronous and active low and clears phase, held fields and valids.
// A stalled result register stops the parser; the input register still takes one more beat.
module framed_crc16_status_receiver_top #(
    parameter int ID_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
    input  logic                        s_axis_tlast,   // burst_last
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [63:0] battery_id, [71:64] charge_level, [87:72] charge_current, [95:88] error_code
    output logic [95:0]                 m_axis_tdata,
    output logic [4:0]                  m_axis_tuser,   // [1:0] frame_status, [4:2] command_kind
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcsr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    fcsr_pkg::t_cfg    w_cfg;
    fcsr_pkg::t_result w_res;
    fcsr_pkg::t_result r_out;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       w_advance;
    logic       w_fire;

    assign w_advance     = !r_out.valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    fcsr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fcsr_parser #(
        .ID_BYTES (ID_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_advance) begin
            r_out.valid <= w_fire && w_res.valid;
        end
        if (w_fire && w_res.valid) begin
            r_out.status  <= w_res.status;
            r_out.kind    <= w_res.kind;
            r_out.id      <= w_res.id;
            r_out.level   <= w_res.level;
            r_out.current <= w_res.current;
            r_out.error   <= w_res.error;
        end
    end

    assign m_axis_tvalid = r_out.valid;
    assign m_axis_tdata  = {r_out.error, r_out.current, r_out.level, r_out.id};
    assign m_axis_tuser  = {r_out.kind, r_out.status};

    a_out_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out.valid) |-> $past(r_in_valid))
        else $error("Result appeared without a parsed beat.");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_last)))
        else $error("Pending input beat was lost or overwritten.");

    a_trunc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res.valid && w_res.status == fcsr_pkg::ST_TRUNC) |-> r_in_last)
        else $error("Truncated status without end of burst.");

endmodule

FILE: rtl/fcsr_regs.sv
// Configuration register file of the framed CRC-16 status receiver.
// APB-style write and read access to the header, end and command code registers.
// Depends on fcsr_pkg.
module fcsr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fcsr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output fcsr_pkg::t_cfg              o_cfg
);

    fcsr_pkg::t_cfg r_cfg;
    logic [2:0]     w_index;
    logic [7:0]     w_rd;

    assign w_index = paddr[fcsr_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header   <= 8'd0;
            r_cfg.end_byte <= 8'd0;
            r_cfg.codes[0] <= 8'd1;
            r_cfg.codes[1] <= 8'd2;
            r_cfg.codes[2] <= 8'd3;
            r_cfg.codes[3] <= 8'd4;
            r_cfg.codes[4] <= 8'd5;
            r_cfg.codes[5] <= 8'd6;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_index)
                fcsr_pkg::REG_HEADER:       r_cfg.header   <= pwdata[7:0];
                fcsr_pkg::REG_END:          r_cfg.end_byte <= pwdata[7:0];
                fcsr_pkg::REG_REPORT_ALL:   r_cfg.codes[0] <= pwdata[7:0];
                fcsr_pkg::REG_READ_ID:      r_cfg.codes[1] <= pwdata[7:0];
                fcsr_pkg::REG_SET_ID_OK:    r_cfg.codes[2] <= pwdata[7:0];
                fcsr_pkg::REG_READ_LEVEL:   r_cfg.codes[3] <= pwdata[7:0];
                fcsr_pkg::REG_READ_CURRENT: r_cfg.codes[4] <= pwdata[7:0];
                fcsr_pkg::REG_READ_ERROR:   r_cfg.codes[5] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            fcsr_pkg::REG_HEADER:       w_rd = r_cfg.header;
            fcsr_pkg::REG_END:          w_rd = r_cfg.end_byte;
            fcsr_pkg::REG_REPORT_ALL:   w_rd = r_cfg.codes[0];
            fcsr_pkg::REG_READ_ID:      w_rd = r_cfg.codes[1];
            fcsr_pkg::REG_SET_ID_OK:    w_rd = r_cfg.codes[2];
            fcsr_pkg::REG_READ_LEVEL:   w_rd = r_cfg.codes[3];
            fcsr_pkg::REG_READ_CURRENT: w_rd = r_cfg.codes[4];
            fcsr_pkg::REG_READ_ERROR:   w_rd = r_cfg.codes[5];
            default:                    w_rd = 8'd0;
        endcase
    end

    assign prdata = {24'd0, w_rd};
    assign o_cfg  = r_cfg;

endmodule

FILE: rtl/fcsr_parser.sv
// Frame parser of the framed CRC-16 status receiver.
// Tracks the frame phase, runs the CRC, collects payload fields and forms one status per frame.
// Depends on fcsr_pkg.
module fcsr_parser #(
    parameter int ID_BYTES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  fcsr_pkg::t_cfg      i_cfg,
    output fcsr_pkg::t_result   o_res
);

    localparam logic [7:0] ID_Q  = 8'(ID_BYTES);
    localparam logic [7:0] B0_Q  = 8'(ID_BYTES + 1);
    localparam logic [7:0] B1_Q  = 8'(ID_BYTES + 2);

    fcsr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rcrc, n_rcrc;
    logic [63:0] r_pend_id, n_pend_id;
    logic [7:0]  r_pend_b0, n_pend_b0;
    logic [7:0]  r_pend_b1, n_pend_b1;
    logic [63:0] r_id, n_id;
    logic [7:0]  r_level, n_level;
    logic [15:0] r_current, n_current;
    logic [7:0]  r_error, n_error;

    logic        w_hdr_hit;
    logic [7:0]  w_len;
    logic [7:0]  w_cmd;
    logic [7:0]  w_q;
    logic        w_in_crc;
    logic        w_crc_hi;
    logic        w_crc_lo;
    logic        w_frame_end;
    logic [7:0]  w_pay;
    logic [2:0]  w_kind_end;
    logic [1:0]  w_status;

    assign w_hdr_hit   = (i_byte == i_cfg.header);
    assign w_len       = (r_pos == 8'd1) ? ((i_byte < fcsr_pkg::MIN_LEN) ? fcsr_pkg::MIN_LEN
                                                                          : i_byte) : r_len;
    assign w_cmd       = (r_pos == 8'd2) ? i_byte : r_cmd;
    assign w_q         = r_pos - 8'd3;
    assign w_in_crc    = (r_pos <= (w_len - 8'd4));
    assign w_crc_hi    = (r_pos == (w_len - 8'd3));
    assign w_crc_lo    = (r_pos == (w_len - 8'd2));
    assign w_frame_end = (r_phase == fcsr_pkg::PH_FRAME) && !w_in_crc && !w_crc_hi && !w_crc_lo;
    assign w_pay       = r_len - fcsr_pkg::MIN_LEN;
    assign w_kind_end  = fcsr_pkg::kind_of(r_cmd, i_cfg);

    always_comb begin
        if (i_byte != i_cfg.end_byte) begin
            w_status = fcsr_pkg::ST_END;
        end else if (r_crc != r_rcrc) begin
            w_status = fcsr_pkg::ST_CRC;
        end else begin
            w_status = fcsr_pkg::ST_GOOD;
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            unique case (r_phase)
                fcsr_pkg::PH_HUNT: begin
                    if (w_hdr_hit) n_phase = fcsr_pkg::PH_FRAME;
                end
                fcsr_pkg::PH_FRAME: begin
                    if (w_frame_end) n_phase = fcsr_pkg::PH_DONE;
                end
                fcsr_pkg::PH_DONE: ;
                default: n_phase = fcsr_pkg::PH_HUNT;
            endcase
            if (i_last) n_phase = fcsr_pkg::PH_HUNT;
        end
    end

    // Datapath and result.
    always_comb begin
        n_len     = r_len;
        n_pos     = r_pos;
        n_cmd     = r_cmd;
        n_crc     = r_crc;
        n_rcrc    = r_rcrc;
        n_pend_id = r_pend_id;
        n_pend_b0 = r_pend_b0;
        n_pend_b1 = r_pend_b1;
        n_id      = r_id;
        n_level   = r_level;
        n_current = r_current;
        n_error   = r_error;
        o_res     = '0;
        if (i_fire) begin
            unique case (r_phase)
                fcsr_pkg::PH_HUNT: begin
                    if (w_hdr_hit) begin
                        n_pos     = 8'd1;
                        n_len     = fcsr_pkg::MIN_LEN;
                        n_cmd     = 8'd0;
                        n_crc     = fcsr_pkg::CRC_INIT;
                        n_rcrc    = 16'd0;
                        n_pend_id = 64'd0;
                        n_pend_b0 = 8'd0;
                        n_pend_b1 = 8'd0;
                    end
                end
                fcsr_pkg::PH_FRAME: begin
                    n_len = w_len;
                    n_cmd = w_cmd;
                    if (w_in_crc) begin
                        n_crc = fcsr_pkg::crc16_byte(r_crc, i_byte);
                        if (r_pos >= 8'd3) begin
                            if (w_q < ID_Q) begin
                                n_pend_id = {r_pend_id[55:0], i_byte};
                            end else if (w_q == ID_Q) begin
                                n_pend_b0 = i_byte;
                            end else if (w_q == B0_Q) begin
                                n_pend_b1 = i_byte;
                            end
                        end
                    end else if (w_crc_hi) begin
                        n_rcrc[15:8] = i_byte;
                    end else if (w_crc_lo) begin
                        n_rcrc[7:0] = i_byte;
                    end
                    if (w_frame_end) begin
                        if (w_status == fcsr_pkg::ST_GOOD && w_kind_end != fcsr_pkg::KIND_OTHER)
                        begin
                            if (w_pay >= ID_Q) n_id = r_pend_id;
                            if ((w_kind_end == fcsr_pkg::KIND_REPORT_ALL ||
                                 w_kind_end == fcsr_pkg::KIND_LEVEL) && w_pay >= B0_Q) begin
                                n_level = r_pend_b0;
                            end
                            if (w_kind_end == fcsr_pkg::KIND_CURRENT && w_pay >= B1_Q) begin
                                n_current = {r_pend_b0, r_pend_b1};
                            end
                            if (w_kind_end == fcsr_pkg::KIND_ERROR && w_pay >= B0_Q) begin
                                n_error = r_pend_b0;
                            end
                        end
                        o_res.valid  = 1'b1;
                        o_res.status = w_status;
                        o_res.kind   = w_kind_end;
                    end else begin
                        n_pos = r_pos + 8'd1;
                    end
                end
                fcsr_pkg::PH_DONE: ;
                default: ;
            endcase
            if (i_last) begin
                if ((r_phase == fcsr_pkg::PH_HUNT && w_hdr_hit) ||
                    (r_phase == fcsr_pkg::PH_FRAME && !w_frame_end)) begin
                    o_res.valid  = 1'b1;
                    o_res.status = fcsr_pkg::ST_TRUNC;
                    o_res.kind   = (r_phase == fcsr_pkg::PH_FRAME && r_pos >= 8'd2)
                                   ? fcsr_pkg::kind_of(w_cmd, i_cfg) : fcsr_pkg::KIND_OTHER;
                end
            end
        end
        o_res.id      = n_id;
        o_res.level   = n_level;
        o_res.current = n_current;
        o_res.error   = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= fcsr_pkg::PH_HUNT;
            r_pos     <= 8'd0;
            r_id      <= 64'd0;
            r_level   <= 8'd0;
            r_current <= 16'd0;
            r_error   <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_id      <= n_id;
            r_level   <= n_level;
            r_current <= n_current;
            r_error   <= n_error;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len     <= n_len;
        r_cmd     <= n_cmd;
        r_crc     <= n_crc;
        r_rcrc    <= n_rcrc;
        r_pend_id <= n_pend_id;
        r_pend_b0 <= n_pend_b0;
        r_pend_b1 <= n_pend_b1;
    end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for framed_crc16_status_receiver_top.
// Holds a byte-level frame tracker that predicts every status beat, plus stream and APB drivers.
// Depends on fcsr_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

import fcsr_pkg::*;

function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
        fb = r[15] ^ b[i];
        r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
endfunction

class rx_frame_tracker;
    localparam int ID_LEN = 8;

    logic [7:0]  hdr = 8'h00;
    logic [7:0]  endb = 8'h00;
    logic [7:0]  codes[6] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6};
    t_phase      cur_phase = PH_HUNT;
    int          pos = 0;
    logic [7:0]  flen = 8'h00;
    logic [7:0]  cmd = 8'h00;
    logic [15:0] crc = 16'h0000;
    logic [15:0] rcrc = 16'h0000;
    logic [63:0] pend_id = '0;
    logic [7:0]  pend_b0 = '0;
    logic [7:0]  pend_b1 = '0;
    logic [63:0] held_id = '0;
    logic [7:0]  held_level = '0;
    logic [15:0] held_current = '0;
    logic [7:0]  held_error = '0;
    t_result     status_due[$];
    int          errors = 0;

    function void set_reg(input logic [2:0] idx, input logic [7:0] v);
        case (idx)
            REG_HEADER: hdr = v;
            REG_END:    endb = v;
            default:    codes[idx - REG_REPORT_ALL] = v;
        endcase
    endfunction

    function logic [2:0] code_kind(input logic [7:0] c);
        logic [2:0] k;
        k = KIND_OTHER;
        for (int i = 5; i >= 0; i--) begin
            if (codes[i] == c) k = 3'(i);
        end
        return k;
    endfunction

    function void push_status(input logic [1:0] st, input logic [2:0] k);
        t_result r;
        r.valid = 1'b1;
        r.status = st;
        r.kind = k;
        r.id = held_id;
        r.level = held_level;
        r.current = held_current;
        r.error = held_error;
        status_due.push_back(r);
    endfunction

    function void commit(input logic [2:0] k);
        int pay;
        pay = int'(flen) - 6;
        if (k == KIND_OTHER) return;
        if (pay >= ID_LEN) held_id = pend_id;
        if ((k == KIND_REPORT_ALL || k == KIND_LEVEL) && pay >= ID_LEN + 1) held_level = pend_b0;
        if (k == KIND_CURRENT && pay >= ID_LEN + 2) held_current = {pend_b0, pend_b1};
        if (k == KIND_ERROR && pay >= ID_LEN + 1) held_error = pend_b0;
    endfunction

    function void take_byte(input logic [7:0] b, input logic fin);
        int p;
        int len;
        int q;
        logic [2:0] k;
        logic [1:0] st;
        if (cur_phase == PH_HUNT) begin
            if (b == hdr) begin
                cur_phase = PH_FRAME;
                pos = 1;
                flen = MIN_LEN;
                cmd = '0;
                crc = CRC_INIT;
                rcrc = '0;
                pend_id = '0;
                pend_b0 = '0;
                pend_b1 = '0;
            end
        end else if (cur_phase == PH_FRAME) begin
            p = pos;
            if (p == 1) flen = (b < MIN_LEN) ? MIN_LEN : b;
            else if (p == 2) cmd = b;
            len = int'(flen);
            if (p <= len - 4) begin
                crc = crc_next(crc, b);
                if (p >= 3) begin
                    q = p - 3;
                    if (q < ID_LEN) pend_id = {pend_id[55:0], b};
                    else if (q == ID_LEN) pend_b0 = b;
                    else if (q == ID_LEN + 1) pend_b1 = b;
                end
            end else if (p == len - 3) begin
                rcrc[15:8] = b;
            end else if (p == len - 2) begin
                rcrc[7:0] = b;
            end else begin
                k = code_kind(cmd);
                if (b != endb) st = ST_END;
                else if (crc != rcrc) st = ST_CRC;
                else st = ST_GOOD;
                if (st == ST_GOOD) commit(k);
                push_status(st, k);
                cur_phase = PH_DONE;
            end
            if (cur_phase == PH_FRAME) pos = p + 1;
        end
        if (fin) begin
            if (cur_phase == PH_FRAME) push_status(ST_TRUNC, (pos > 2) ? code_kind(cmd) : KIND_OTHER);
            cur_phase = PH_HUNT;
        end
    endfunction

    function int pending();
        return status_due.size();
    endfunction

    function void check_status(input logic [4:0] user, input logic [95:0] data);
        t_result w;
        if (status_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected status beat: tuser %h tdata %h", user, data);
            return;
        end
        w = status_due.pop_front();
        if (user[1:0] !== w.status || user[4:2] !== w.kind || data[63:0] !== w.id ||
            data[71:64] !== w.level || data[87:72] !== w.current || data[95:88] !== w.error) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch expected: status %0d kind %0d id %h level %h current %h error %h",
                         w.status, w.kind, w.id, w.level, w.current, w.error);
                $display("         actual:   status %0d kind %0d id %h level %h current %h error %h",
                         user[1:0], user[4:2], data[63:0], data[71:64], data[87:72], data[95:88]);
            end
        end
    endfunction
endclass

module testbench;
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [95:0]         m_axis_tdata;
    logic [4:0]          m_axis_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    rx_frame_tracker tracker = new();
    logic [7:0]      bq[$];
    int              send_idle = 0;
    int              recv_stall = 0;
    int              beats_sent = 0;
    int              target;

    framed_crc16_status_receiver_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) tracker.check_status(m_axis_tuser, m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic apb_write(input logic [2:0] idx, input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h000000, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, v);
    endtask

    task automatic set_config(input logic [63:0] v);
        apb_write(REG_HEADER, v[7:0]);
        apb_write(REG_END, v[15:8]);
        apb_write(REG_REPORT_ALL, v[23:16]);
        apb_write(REG_READ_ID, v[31:24]);
        apb_write(REG_SET_ID_OK, v[39:32]);
        apb_write(REG_READ_LEVEL, v[47:40]);
        apb_write(REG_READ_CURRENT, v[55:48]);
        apb_write(REG_READ_ERROR, v[63:56]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_beat(input logic [7:0] b, input logic fin);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_byte(b, fin);
        beats_sent++;
    endtask

    task automatic send_burst();
        foreach (bq[i]) send_beat(bq[i], i == bq.size() - 1);
        bq.delete();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic void add_frame(input logic [7:0] len_b, input logic [7:0] cmd_b,
                                      input bit bad_crc, input bit bad_end);
        int len;
        logic [15:0] c;
        logic [7:0] b;
        len = (len_b < MIN_LEN) ? int'(MIN_LEN) : int'(len_b);
        bq.push_back(tracker.hdr);
        bq.push_back(len_b);
        bq.push_back(cmd_b);
        c = crc_next(crc_next(CRC_INIT, len_b), cmd_b);
        for (int i = 0; i < len - 6; i++) begin
            b = 8'($urandom);
            bq.push_back(b);
            c = crc_next(c, b);
        end
        if (bad_crc) c = c ^ 16'(1 << $urandom_range(15));
        bq.push_back(c[15:8]);
        bq.push_back(c[7:0]);
        bq.push_back(bad_end ? (tracker.endb ^ 8'(1 << $urandom_range(7))) : tracker.endb);
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'($urandom_range(5));
        if (r < 45) return 8'($urandom_range(13, 6));
        if (r < 90) return 8'($urandom_range(17, 14));
        if (r < 97) return 8'($urandom_range(40, 18));
        return 8'($urandom_range(255, 41));
    endfunction

    function automatic void add_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom); while (b == tracker.hdr);
            bq.push_back(b);
        end
    endfunction

    task automatic random_burst();
        int start;
        int cut;
        logic [7:0] c;
        if ($urandom_range(99) < 8) begin
            add_noise($urandom_range(4, 1));
        end else begin
            add_noise($urandom_range(3));
            start = bq.size();
            c = ($urandom_range(99) < 85) ? tracker.codes[$urandom_range(5)] : 8'($urandom);
            add_frame(pick_length(), c, $urandom_range(99) < 12, $urandom_range(99) < 10);
            if ($urandom_range(99) < 12) begin
                cut = $urandom_range(bq.size() - 1, start + 1);
                while (bq.size() > cut) void'(bq.pop_back());
            end else begin
                repeat ($urandom_range(3)) bq.push_back(8'($urandom));
            end
        end
        send_burst();
    endtask

    task automatic directed();
        bq.push_back(8'h00);
        bq.push_back(8'hFF);
        send_burst();
        add_frame(8'd16, tracker.codes[KIND_CURRENT], 1'b0, 1'b0);
        bq.push_back(tracker.hdr);
        send_burst();
        add_frame(8'd0, tracker.codes[KIND_REPORT_ALL], 1'b0, 1'b0);
        send_burst();
        add_frame(8'd6, tracker.codes[KIND_LEVEL], 1'b1, 1'b1);
        send_burst();
        bq.push_back(tracker.hdr);
        send_burst();
        bq.push_back(tracker.hdr);
        bq.push_back(8'd20);
        send_burst();
    endtask

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_config(64'h06050403_02015AA5);
                1: set_config(64'h60504030_2010FF00);
                2: set_config(64'hFE017F80_00FF00FF);
                3: set_config(64'h03030707_09097E7E);
                default: set_config({$urandom, $urandom});
            endcase
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 77; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 77; end
                default: begin send_idle = 30; recv_stall = 30; end
            endcase
            if (ph == 0) directed();
            target = beats_sent + 100;
            while (beats_sent < target) random_burst();
            drain();
        end
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
